[rtl/dual_pid_step_top_defines.svh]
// assertion macros for the dual pid step block
// used by the port checker; needs clk and rst_n in scope where expanded
`ifndef DUAL_PID_STEP_TOP_DEFINES_SVH
`define DUAL_PID_STEP_TOP_DEFINES_SVH

// same-cycle implication, quiet during reset
`define DPS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dps check failed");

// next-cycle implication, quiet during reset
`define DPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dps check failed");

// condition that must follow a reset cycle
`define DPS_ASSERT_AFTER_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("dps reset check failed");

`endif

[rtl/dps_pkg.sv]
// shared types and constants for the dual pid step block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dps_pkg;

  // field widths fixed by the interface
  localparam int MEAS_W     = 8;
  localparam int ERR_W      = 9;
  localparam int DER_W      = 10;
  localparam int GAIN_W     = 16;
  localparam int DRIVE_W    = 24;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // drive saturation limits
  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = {1'b0, {(DRIVE_W-1){1'b1}}};
  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};

  // configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANGLE_SETPOINT    = 4'd0,
    REG_DISTANCE_SETPOINT = 4'd1,
    REG_ANGLE_KP          = 4'd2,
    REG_ANGLE_KI          = 4'd3,
    REG_ANGLE_KD          = 4'd4,
    REG_DISTANCE_KP       = 4'd5,
    REG_DISTANCE_KI       = 4'd6,
    REG_DISTANCE_KD       = 4'd7
  } cfg_reg_t;

  // pipeline control handed to each lane
  typedef struct packed {
    logic load;   // word accepted: run error, integral and derivative stage
    logic adv;    // pipeline moves: capture products
  } lane_ctl_t;

endpackage

`default_nettype wire

[rtl/dual_pid_step_top.sv]
// Dual PID step: two PID lanes (angle and distance) take one measurement word per
// cycle while in_ready is high; words pass lane state, product and output registers.
// The sustained rate is one word per clock, set by the lane pipeline
// (error/integral update, gain products, sum and clamp) and the output skid slot;
// in_ready falls only when both the output register and the skid slot are full.
// Gains are signed Q8.8; configuration writes are taken at any time the port is
// enabled and are expected while the block is idle.
// depends on dps_pkg, dps_lane and dps_merge
`timescale 1ns / 1ps
`default_nettype none

module dual_pid_step_top #(
  parameter int INTEGRAL_BITS  = 20,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   cfg_we,
  input  wire  [dps_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire  [dps_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire  [dps_pkg::MEAS_W-1:0]            in_angle_measure,
  input  wire  [dps_pkg::MEAS_W-1:0]            in_distance_measure,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic signed [dps_pkg::DRIVE_W-1:0]    out_angle_drive,
  output logic signed [dps_pkg::DRIVE_W-1:0]    out_distance_drive
);

  logic        [dps_pkg::MEAS_W-1:0]  angle_sp_r;
  logic        [dps_pkg::MEAS_W-1:0]  dist_sp_r;
  logic signed [dps_pkg::GAIN_W-1:0]  angle_kp_r;
  logic signed [dps_pkg::GAIN_W-1:0]  angle_ki_r;
  logic signed [dps_pkg::GAIN_W-1:0]  angle_kd_r;
  logic signed [dps_pkg::GAIN_W-1:0]  dist_kp_r;
  logic signed [dps_pkg::GAIN_W-1:0]  dist_ki_r;
  logic signed [dps_pkg::GAIN_W-1:0]  dist_kd_r;

  logic                               va_r;
  logic                               vb_r;
  logic                               mrg_ready;
  dps_pkg::lane_ctl_t                 ctl;
  logic signed [dps_pkg::DRIVE_W-1:0] angle_drive;
  logic signed [dps_pkg::DRIVE_W-1:0] dist_drive;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_sp_r <= '0;
      dist_sp_r  <= '0;
      angle_kp_r <= '0;
      angle_ki_r <= '0;
      angle_kd_r <= '0;
      dist_kp_r  <= '0;
      dist_ki_r  <= '0;
      dist_kd_r  <= '0;
    end else if (cfg_we) begin
      case (dps_pkg::cfg_reg_t'(cfg_index))
        dps_pkg::REG_ANGLE_SETPOINT:    angle_sp_r <= cfg_data[dps_pkg::MEAS_W-1:0];
        dps_pkg::REG_DISTANCE_SETPOINT: dist_sp_r  <= cfg_data[dps_pkg::MEAS_W-1:0];
        dps_pkg::REG_ANGLE_KP:          angle_kp_r <= $signed(cfg_data);
        dps_pkg::REG_ANGLE_KI:          angle_ki_r <= $signed(cfg_data);
        dps_pkg::REG_ANGLE_KD:          angle_kd_r <= $signed(cfg_data);
        dps_pkg::REG_DISTANCE_KP:       dist_kp_r  <= $signed(cfg_data);
        dps_pkg::REG_DISTANCE_KI:       dist_ki_r  <= $signed(cfg_data);
        dps_pkg::REG_DISTANCE_KD:       dist_kd_r  <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // pipeline moves whenever the merging stage has room
  assign in_ready = mrg_ready;
  assign ctl.load = in_valid && mrg_ready;
  assign ctl.adv  = mrg_ready;

  // stage valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (mrg_ready) begin
      va_r <= in_valid;
      vb_r <= va_r;
    end
  end

  // angle lane
  dps_lane #(
    .INTEGRAL_BITS  (INTEGRAL_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_lane_angle (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .setpoint (angle_sp_r),
    .measure  (in_angle_measure),
    .kp       (angle_kp_r),
    .ki       (angle_ki_r),
    .kd       (angle_kd_r),
    .drive    (angle_drive)
  );

  // distance lane
  dps_lane #(
    .INTEGRAL_BITS  (INTEGRAL_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_lane_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .setpoint (dist_sp_r),
    .measure  (in_distance_measure),
    .kp       (dist_kp_r),
    .ki       (dist_ki_r),
    .kd       (dist_kd_r),
    .drive    (dist_drive)
  );

  // result word assembly and output buffering
  dps_merge u_merge (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (vb_r && mrg_ready),
    .angle_drive        (angle_drive),
    .distance_drive     (dist_drive),
    .ready              (mrg_ready),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_angle_drive    (out_angle_drive),
    .out_distance_drive (out_distance_drive)
  );

endmodule

`default_nettype wire

[rtl/dps_lane.sv]
// one pid channel: error/integral/derivative stage, product stage, sum and clamp
// depends on dps_pkg
`timescale 1ns / 1ps
`default_nettype none

module dps_lane #(
  parameter int INTEGRAL_BITS  = 20,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  wire                                      clk,
  input  wire                                      rst_n,
  input  dps_pkg::lane_ctl_t                       ctl,
  input  wire        [dps_pkg::MEAS_W-1:0]         setpoint,
  input  wire        [dps_pkg::MEAS_W-1:0]         measure,
  input  wire signed [dps_pkg::GAIN_W-1:0]         kp,
  input  wire signed [dps_pkg::GAIN_W-1:0]         ki,
  input  wire signed [dps_pkg::GAIN_W-1:0]         kd,
  output logic signed [dps_pkg::DRIVE_W-1:0]       drive
);

  localparam int ISUM_W = INTEGRAL_BITS + 1;
  localparam int PP_W   = dps_pkg::GAIN_W + dps_pkg::ERR_W;
  localparam int PI_W   = dps_pkg::GAIN_W + INTEGRAL_BITS;
  localparam int PD_W   = dps_pkg::GAIN_W + dps_pkg::DER_W;
  localparam int SUM_W  = ((PI_W > PD_W) ? PI_W : PD_W) + 2;

  localparam logic signed [INTEGRAL_BITS-1:0] INT_MAX =
    {1'b0, {(INTEGRAL_BITS-1){1'b1}}};
  localparam logic signed [INTEGRAL_BITS-1:0] INT_MIN =
    {1'b1, {(INTEGRAL_BITS-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] TRUNC_BIAS =
    SUM_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

  logic signed [dps_pkg::ERR_W-1:0]  err;
  logic signed [ISUM_W-1:0]          integ_sum;
  logic signed [INTEGRAL_BITS-1:0]   integ_nxt;
  logic signed [dps_pkg::DER_W-1:0]  der_nxt;

  // integ_r and last_err_r double as the first stage of the pipeline
  logic signed [INTEGRAL_BITS-1:0]   integ_r;
  logic signed [dps_pkg::ERR_W-1:0]  last_err_r;
  logic signed [dps_pkg::DER_W-1:0]  der_r;

  logic signed [PP_W-1:0]            prod_p_r;
  logic signed [PI_W-1:0]            prod_i_r;
  logic signed [PD_W-1:0]            prod_d_r;

  logic signed [SUM_W-1:0]           sum;
  logic signed [SUM_W-1:0]           biased;
  logic signed [SUM_W-1:0]           quot;

  // error, saturating integral and derivative
  assign err = $signed({1'b0, setpoint}) - $signed({1'b0, measure});
  assign integ_sum = ISUM_W'(integ_r) + ISUM_W'(err);
  assign der_nxt = dps_pkg::DER_W'(err) - dps_pkg::DER_W'(last_err_r);

  always_comb begin
    if (integ_sum > ISUM_W'(INT_MAX)) begin
      integ_nxt = INT_MAX;
    end else if (integ_sum < ISUM_W'(INT_MIN)) begin
      integ_nxt = INT_MIN;
    end else begin
      integ_nxt = $signed(integ_sum[INTEGRAL_BITS-1:0]);
    end
  end

  // channel state, updated once per accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r    <= '0;
      last_err_r <= '0;
    end else if (ctl.load) begin
      integ_r    <= integ_nxt;
      last_err_r <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      der_r <= der_nxt;
    end
  end

  // gain products
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      prod_p_r <= PP_W'(kp) * PP_W'(last_err_r);
      prod_i_r <= PI_W'(ki) * PI_W'(integ_r);
      prod_d_r <= PD_W'(kd) * PD_W'(der_r);
    end
  end

  // sum, shift toward zero and clamp to the drive range
  assign sum    = SUM_W'(prod_p_r) + SUM_W'(prod_i_r) + SUM_W'(prod_d_r);
  assign biased = sum + (sum[SUM_W-1] ? TRUNC_BIAS : '0);
  assign quot   = biased >>> GAIN_FRAC_BITS;

  always_comb begin
    if (quot > SUM_W'(dps_pkg::DRIVE_MAX)) begin
      drive = dps_pkg::DRIVE_MAX;
    end else if (quot < SUM_W'(dps_pkg::DRIVE_MIN)) begin
      drive = dps_pkg::DRIVE_MIN;
    end else begin
      drive = $signed(quot[dps_pkg::DRIVE_W-1:0]);
    end
  end

endmodule

`default_nettype wire

[rtl/dps_merge.sv]
// merging stage: joins both lane drives into one result word behind a skid register
// depends on dps_pkg
`timescale 1ns / 1ps
`default_nettype none

module dps_merge (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  push,
  input  wire  signed [dps_pkg::DRIVE_W-1:0]   angle_drive,
  input  wire  signed [dps_pkg::DRIVE_W-1:0]   distance_drive,
  output logic                                 ready,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic signed [dps_pkg::DRIVE_W-1:0]   out_angle_drive,
  output logic signed [dps_pkg::DRIVE_W-1:0]   out_distance_drive
);

  logic                                 main_valid_r;
  logic                                 skid_valid_r;
  logic signed [dps_pkg::DRIVE_W-1:0]   main_angle_r;
  logic signed [dps_pkg::DRIVE_W-1:0]   main_dist_r;
  logic signed [dps_pkg::DRIVE_W-1:0]   skid_angle_r;
  logic signed [dps_pkg::DRIVE_W-1:0]   skid_dist_r;
  logic                                 take;

  assign take  = main_valid_r && out_ready;
  assign ready = !skid_valid_r;

  // valid flags of output and skid slots
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (take) begin
      if (skid_valid_r) begin
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= push;
      end
    end else if (push) begin
      if (main_valid_r) begin
        skid_valid_r <= 1'b1;
      end else begin
        main_valid_r <= 1'b1;
      end
    end
  end

  // word payloads
  always_ff @(posedge clk) begin
    if (take && skid_valid_r) begin
      main_angle_r <= skid_angle_r;
      main_dist_r  <= skid_dist_r;
    end else if (push && (take || !main_valid_r)) begin
      main_angle_r <= angle_drive;
      main_dist_r  <= distance_drive;
    end
    if (push && main_valid_r && !take) begin
      skid_angle_r <= angle_drive;
      skid_dist_r  <= distance_drive;
    end
  end

  assign out_valid          = main_valid_r;
  assign out_angle_drive    = main_angle_r;
  assign out_distance_drive = main_dist_r;

endmodule

`default_nettype wire

[rtl/dps_checker.sv]
// port-level checks for the dual pid step block, bound to the top level
// depends on dual_pid_step_top_defines.svh and dps_pkg
`timescale 1ns / 1ps
`default_nettype none
`include "dual_pid_step_top_defines.svh"

module dps_checker (
  input wire                                clk,
  input wire                                rst_n,
  input wire                                in_valid,
  input wire                                in_ready,
  input wire                                out_valid,
  input wire                                out_ready,
  input wire signed [dps_pkg::DRIVE_W-1:0]  out_angle_drive,
  input wire signed [dps_pkg::DRIVE_W-1:0]  out_distance_drive
);

  // no word is left over from before reset
  `DPS_ASSERT_AFTER_RST(a_out_clear_after_rst, !out_valid && in_ready)

  // a stalled word holds
  `DPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_angle_drive) && $stable(out_distance_drive))

  // an offered input word stays offered until taken
  `DPS_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid)

  // input back-pressure only with a word waiting at the output
  `DPS_ASSERT_IMP(a_stall_needs_word, !in_ready, out_valid)

  // input stalls only after the output was refused
  `DPS_ASSERT_IMP(a_stall_cause, !in_ready, $past(out_valid && !out_ready))

endmodule

bind dual_pid_step_top dps_checker u_dps_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_angle_drive    (out_angle_drive),
  .out_distance_drive (out_distance_drive)
);

`default_nettype wire

[verif/tb_dual_pid_step_top.sv]
// self-checking testbench for dual_pid_step_top: directed, wind-up and random words
// depends on dps_pkg and the dual_pid_step_top rtl
`timescale 1ns / 1ps

module tb_dual_pid_step_top;

  localparam int INTEG_BITS = 20;
  localparam int GAIN_FRAC  = 8;
  localparam int NUM_REGS   = 8;
  localparam int LATENCY    = 3;
  localparam longint INTEG_MAX = (longint'(1) <<< (INTEG_BITS - 1)) - 1;
  localparam longint INTEG_MIN = -INTEG_MAX - 1;

  // idling modes of the two channels
  localparam int IDLE_NONE   = 0;
  localparam int IDLE_SEND   = 1;
  localparam int IDLE_RECV   = 2;
  localparam int IDLE_BOTH   = 3;

  logic                               clk;
  logic                               rst_n = 1'b0;
  logic                               cfg_we = 1'b0;
  logic [dps_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
  logic [dps_pkg::CFG_DATA_W-1:0]     cfg_data = '0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic [dps_pkg::MEAS_W-1:0]         in_angle_measure = '0;
  logic [dps_pkg::MEAS_W-1:0]         in_distance_measure = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic signed [dps_pkg::DRIVE_W-1:0] out_angle_drive;
  logic signed [dps_pkg::DRIVE_W-1:0] out_distance_drive;

  int idle_mode = IDLE_NONE;

  typedef struct {
    logic signed [dps_pkg::DRIVE_W-1:0] angle;
    logic signed [dps_pkg::DRIVE_W-1:0] distance;
  } drive_word_t;

  // pid predictor with its own registers and channel state, plus the drive checker
  class pid_scoreboard;
    drive_word_t                        drive_q[$];
    logic [dps_pkg::MEAS_W-1:0]         setpoint[2];
    logic signed [dps_pkg::GAIN_W-1:0]  kp[2];
    logic signed [dps_pkg::GAIN_W-1:0]  ki[2];
    logic signed [dps_pkg::GAIN_W-1:0]  kd[2];
    longint                             integ[2];
    longint                             last_err[2];
    int                                 errors;

    function new();
      foreach (setpoint[i]) begin
        setpoint[i] = '0;
        kp[i] = '0;
        ki[i] = '0;
        kd[i] = '0;
        integ[i] = 0;
        last_err[i] = 0;
      end
      errors = 0;
    endfunction

    function void set_reg(logic [dps_pkg::CFG_IDX_W-1:0] idx,
                          logic [dps_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        dps_pkg::REG_ANGLE_SETPOINT:    setpoint[0] = data[dps_pkg::MEAS_W-1:0];
        dps_pkg::REG_DISTANCE_SETPOINT: setpoint[1] = data[dps_pkg::MEAS_W-1:0];
        dps_pkg::REG_ANGLE_KP:          kp[0] = data;
        dps_pkg::REG_ANGLE_KI:          ki[0] = data;
        dps_pkg::REG_ANGLE_KD:          kd[0] = data;
        dps_pkg::REG_DISTANCE_KP:       kp[1] = data;
        dps_pkg::REG_DISTANCE_KI:       ki[1] = data;
        dps_pkg::REG_DISTANCE_KD:       kd[1] = data;
        default: ;
      endcase
    endfunction

    // one pid step of a channel; integral clamps before it feeds the sum
    function logic signed [dps_pkg::DRIVE_W-1:0] pid_drive(int ch,
                                                           logic [dps_pkg::MEAS_W-1:0] meas);
      longint err;
      longint der;
      longint sum;
      longint q;
      err = longint'(setpoint[ch]) - longint'(meas);
      der = err - last_err[ch];
      integ[ch] = integ[ch] + err;
      if (integ[ch] > INTEG_MAX) integ[ch] = INTEG_MAX;
      if (integ[ch] < INTEG_MIN) integ[ch] = INTEG_MIN;
      sum = longint'(kp[ch]) * err + longint'(ki[ch]) * integ[ch]
          + longint'(kd[ch]) * der;
      // signed division truncates toward zero
      q = sum / (longint'(1) <<< GAIN_FRAC);
      if (q > longint'(dps_pkg::DRIVE_MAX)) q = longint'(dps_pkg::DRIVE_MAX);
      if (q < longint'(dps_pkg::DRIVE_MIN)) q = longint'(dps_pkg::DRIVE_MIN);
      last_err[ch] = err;
      return q[dps_pkg::DRIVE_W-1:0];
    endfunction

    function void note_input(logic [dps_pkg::MEAS_W-1:0] a, logic [dps_pkg::MEAS_W-1:0] d);
      drive_word_t w;
      w.angle = pid_drive(0, a);
      w.distance = pid_drive(1, d);
      drive_q.push_back(w);
    endfunction

    function void check_drive(logic signed [dps_pkg::DRIVE_W-1:0] a,
                              logic signed [dps_pkg::DRIVE_W-1:0] d);
      drive_word_t w;
      if (drive_q.size() == 0) begin
        $display("%0t unexpected drive word: angle %0d distance %0d", $time, a, d);
        errors++;
        return;
      end
      w = drive_q.pop_front();
      if (a !== w.angle) begin
        $display("%0t angle_drive mismatch: expected %0d, got %0d", $time, w.angle, a);
        errors++;
      end
      if (d !== w.distance) begin
        $display("%0t distance_drive mismatch: expected %0d, got %0d", $time, w.distance, d);
        errors++;
      end
    endfunction

    function int pending();
      return drive_q.size();
    endfunction
  endclass

  pid_scoreboard sb = new();

  dual_pid_step_top #(
    .INTEGRAL_BITS  (INTEG_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_angle_measure    (in_angle_measure),
    .in_distance_measure (in_distance_measure),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_angle_drive     (out_angle_drive),
    .out_distance_drive  (out_distance_drive)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // receiver stalls by idling mode
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    out_ready <= !((idle_mode == IDLE_RECV && r < 77) || (idle_mode == IDLE_BOTH && r < 11));
  end

  // drive word monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_drive(out_angle_drive, out_distance_drive);
  end

  function automatic bit sender_waits();
    int r;
    r = $urandom_range(0, 99);
    return (idle_mode == IDLE_SEND && r < 77) || (idle_mode == IDLE_BOTH && r < 11);
  endfunction

  // extremes often, otherwise any value
  function automatic logic [dps_pkg::GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // single register write, enable left high for the caller
  task automatic write_reg(input logic [dps_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dps_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  // full register set, with junk in the unused setpoint bits and a stray index
  task automatic configure(input logic [dps_pkg::MEAS_W-1:0] sp_a,
                           input logic [dps_pkg::MEAS_W-1:0] sp_d,
                           input logic [dps_pkg::GAIN_W-1:0] akp,
                           input logic [dps_pkg::GAIN_W-1:0] aki,
                           input logic [dps_pkg::GAIN_W-1:0] akd,
                           input logic [dps_pkg::GAIN_W-1:0] dkp,
                           input logic [dps_pkg::GAIN_W-1:0] dki,
                           input logic [dps_pkg::GAIN_W-1:0] dkd);
    write_reg(dps_pkg::CFG_IDX_W'(NUM_REGS + $urandom_range(0, 7)), 16'($urandom));
    write_reg(dps_pkg::REG_ANGLE_SETPOINT, {8'($urandom), sp_a});
    write_reg(dps_pkg::REG_DISTANCE_SETPOINT, {8'($urandom), sp_d});
    write_reg(dps_pkg::REG_ANGLE_KP, akp);
    write_reg(dps_pkg::REG_ANGLE_KI, aki);
    write_reg(dps_pkg::REG_ANGLE_KD, akd);
    write_reg(dps_pkg::REG_DISTANCE_KP, dkp);
    write_reg(dps_pkg::REG_DISTANCE_KI, dki);
    write_reg(dps_pkg::REG_DISTANCE_KD, dkd);
    cfg_we <= 1'b0;
  endtask

  // one measurement word through the handshake
  task automatic send_word(input logic [dps_pkg::MEAS_W-1:0] a,
                           input logic [dps_pkg::MEAS_W-1:0] d);
    while (sender_waits()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_angle_measure <= a;
    in_distance_measure <= d;
    do @(posedge clk); while (!in_ready);
    sb.note_input(a, d);
  endtask

  // hold off until every drive word is back, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic logic [dps_pkg::MEAS_W-1:0] pick_meas();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 39) == 0) settle();
      send_word(pick_meas(), pick_meas());
    end
    settle();
  endtask

  // stimulus
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // tiny gains: a sum of minus one must truncate to zero
    configure(8'd0, 8'd255, 16'h0001, 16'h0000, 16'h0000, 16'h0001, 16'h0001, 16'h0001);
    send_word(8'd1, 8'd254);
    send_word(8'd0, 8'd0);
    send_word(8'd255, 8'd255);
    send_word(8'd0, 8'd255);
    send_word(8'd255, 8'd0);
    settle();

    // largest positive gains, walking one and walking zero
    configure(8'd255, 8'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    for (int k = 0; k < dps_pkg::MEAS_W; k++) send_word(8'(1 << k), ~8'(1 << k));
    settle();

    // most negative gains
    configure(8'd128, 8'd127, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_word(8'd0, 8'd255);
    send_word(8'd255, 8'd0);
    send_word(8'd128, 8'd127);
    send_word(8'd0, 8'd0);
    settle();

    // wind-up with full integral gain: angle drive saturates high, distance low
    configure(8'd255, 8'd0, pick_gain(), 16'h7FFF, pick_gain(),
              pick_gain(), 16'h7FFF, pick_gain());
    for (int i = 0; i < 280; i++)
      send_word(8'($urandom_range(0, 15)), 8'($urandom_range(240, 255)));
    settle();

    // unwind with the integral kept: drives leave saturation and come back into range
    configure(8'd0, 8'd255, pick_gain(), 16'h7FFF, pick_gain(),
              pick_gain(), 16'h7FFF, pick_gain());
    for (int i = 0; i < 60; i++)
      send_word(8'($urandom_range(240, 255)), 8'($urandom_range(0, 15)));
    settle();

    // random words under every idling mode, two register sets each
    for (int m = IDLE_NONE; m <= IDLE_BOTH; m++) begin
      idle_mode = m;
      for (int s = 0; s < 2; s++) begin
        configure(8'($urandom), 8'($urandom), pick_gain(), pick_gain(), pick_gain(),
                  pick_gain(), pick_gain(), pick_gain());
        run_random(18);
      end
    end

    idle_mode = IDLE_NONE;
    repeat (LATENCY + 10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
